// ----- design/pbpd_pkg.sv -----
package pbpd_pkg;

   localparam int MAX_PLANES_DEF  = 8;
   localparam int OFFSET_BITS_DEF = 18;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   // register indexes on the csr channel
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_BYTES   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLANE_COUNT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_COUNT   = 2'd2;

   localparam logic [7:0]  ROW_BYTES_RST   = 8'd40;
   localparam logic [3:0]  PLANE_COUNT_RST = 4'd3;
   localparam logic [10:0] ROW_COUNT_RST   = 11'd200;
   localparam logic [10:0] ROW_LIMIT       = 11'd1024;

   localparam logic [7:0] HDR_NOP = 8'h80;

   typedef struct packed {
      logic [7:0]  row_bytes;
      logic [3:0]  plane_count;
      logic [10:0] row_count;
   } cfg_type;

endpackage

// ----- design/pbpd_csr.sv -----
module pbpd_csr
   import pbpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_ROW_BYTES:   cfg_in.row_bytes   = csr_wdata[7:0];
            CSR_PLANE_COUNT: cfg_in.plane_count = csr_wdata[3:0];
            CSR_ROW_COUNT:   cfg_in.row_count   = csr_wdata[10:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_bytes   <= ROW_BYTES_RST;
         cfg_ff.plane_count <= PLANE_COUNT_RST;
         cfg_ff.row_count   <= ROW_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/pbpd_engine.sv -----
module pbpd_engine
   import pbpd_pkg::*;
#(
   parameter int MAX_PLANES  = MAX_PLANES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             coded_byte,
   input  cfg_type                cfg,
   output logic                   emit,
   output logic [2:0]             plane_index,
   output logic [OFFSET_BITS-1:0] plane_offset,
   output logic [7:0]             run_value,
   output logic [7:0]             run_length,
   output logic                   row_overrun,
   output logic                   image_done,
   output logic                   finished
);

   localparam int PIDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   localparam logic [1:0] MODE_HEADER  = 2'd0;
   localparam logic [1:0] MODE_LITERAL = 2'd1;
   localparam logic [1:0] MODE_REPEAT  = 2'd2;

   logic [1:0]             mode_ff, mode_in;
   logic [7:0]             lit_ff, lit_in;
   logic [7:0]             rep_ff, rep_in;
   logic [8:0]             filled_ff, filled_in;
   logic [2:0]             plane_ff, plane_in;
   logic [9:0]             row_ff, row_in;
   logic                   fin_ff, fin_in;
   logic [OFFSET_BITS-1:0] offs_ff [MAX_PLANES];
   logic [OFFSET_BITS-1:0] offs_in;

   logic [2:0]        plane_sel;
   logic [PIDX_W-1:0] pidx;
   logic [3:0]        eff_planes;
   logic [10:0]       eff_rows;
   logic [7:0]        lit_dec;
   logic [7:0]        len;
   logic              packet_end;
   logic              run_now;
   logic [8:0]        filled_sum;
   logic              row_close;
   logic              last_plane;
   logic              last_row;

   // a plane beyond the table falls back to plane 0
   assign plane_sel = ({1'b0, plane_ff} < 4'(MAX_PLANES)) ? plane_ff : 3'd0;
   assign pidx      = plane_sel[PIDX_W-1:0];

   always_comb begin
      if (cfg.plane_count == 4'd0)                eff_planes = 4'd1;
      else if (cfg.plane_count > 4'(MAX_PLANES))  eff_planes = 4'(MAX_PLANES);
      else                                        eff_planes = cfg.plane_count;
      if (cfg.row_count == 11'd0)                 eff_rows = 11'd1;
      else if (cfg.row_count > ROW_LIMIT)         eff_rows = ROW_LIMIT;
      else                                        eff_rows = cfg.row_count;
   end

   assign lit_dec    = lit_ff - 8'd1;
   assign run_now    = !fin_ff && (mode_ff == MODE_LITERAL || mode_ff == MODE_REPEAT);
   assign len        = (mode_ff == MODE_LITERAL) ? 8'd1 : rep_ff;
   assign packet_end = (mode_ff == MODE_LITERAL) ? (lit_dec == 8'd0) : 1'b1;
   assign filled_sum = filled_ff + {1'b0, len};
   assign row_close  = packet_end && (filled_sum >= {1'b0, cfg.row_bytes});
   assign last_plane = ({1'b0, plane_sel} + 4'd1) >= eff_planes;
   assign last_row   = ({1'b0, row_ff} + 11'd1) >= eff_rows;

   assign emit         = run_now;
   assign plane_index  = plane_sel;
   assign plane_offset = offs_ff[pidx];
   assign run_value    = coded_byte;
   assign run_length   = len;
   assign row_overrun  = filled_sum > {1'b0, cfg.row_bytes};
   assign image_done   = row_close && last_plane && last_row;
   assign finished     = fin_ff;
   assign offs_in      = offs_ff[pidx] + OFFSET_BITS'(len);

   always_comb begin
      mode_in   = mode_ff;
      lit_in    = lit_ff;
      rep_in    = rep_ff;
      filled_in = filled_ff;
      plane_in  = plane_ff;
      row_in    = row_ff;
      fin_in    = fin_ff;
      if (!fin_ff) begin
         if (run_now) begin
            if (mode_ff == MODE_LITERAL) begin
               lit_in = lit_dec;
               if (packet_end) mode_in = MODE_HEADER;
            end else begin
               mode_in = MODE_HEADER;
               rep_in  = 8'd0;
            end
            filled_in = filled_sum;
            if (row_close) begin
               filled_in = 9'd0;
               if (last_plane) begin
                  plane_in = 3'd0;
                  if (last_row) begin
                     fin_in = 1'b1;
                     row_in = 10'd0;
                  end else begin
                     row_in = row_ff + 10'd1;
                  end
               end else begin
                  plane_in = plane_sel + 3'd1;
               end
            end
         end else begin
            // header byte
            if (coded_byte < HDR_NOP) begin
               lit_in  = coded_byte + 8'd1;
               mode_in = MODE_LITERAL;
            end else if (coded_byte > HDR_NOP) begin
               rep_in  = 8'(9'd257 - {1'b0, coded_byte});
               mode_in = MODE_REPEAT;
            end else begin
               mode_in = MODE_HEADER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HEADER;
         lit_ff    <= 8'd0;
         rep_ff    <= 8'd0;
         filled_ff <= 9'd0;
         plane_ff  <= 3'd0;
         row_ff    <= 10'd0;
         fin_ff    <= 1'b0;
         for (int i = 0; i < MAX_PLANES; i++) begin
            offs_ff[i] <= '0;
         end
      end else if (step_en) begin
         mode_ff   <= mode_in;
         lit_ff    <= lit_in;
         rep_ff    <= rep_in;
         filled_ff <= filled_in;
         plane_ff  <= plane_in;
         row_ff    <= row_in;
         fin_ff    <= fin_in;
         if (run_now) begin
            offs_ff[pidx] <= offs_in;
         end
      end
   end

endmodule

// ----- design/packbits_planar_decoder_unit.sv -----
// PackBits planar decoder: one compressed byte per req beat, at most one run per rsp beat.
// req channel: req_tdata[7:0] carries the next stream byte (header or data).
// rsp channel: one beat per decoded run; rsp_tlast marks the run that closes the
// last image row, rsp_tuser flags a run that passed the end of its row.
// csr channel: csr_addr selects row_bytes (0), plane_count (1) or row_count (2);
// other indexes are dropped. csr_ready is always high; write only while idle.
// A byte accepted on req goes into the input register; when the engine steps it,
// its run is loaded into the rsp register and rsp_tvalid rises.
// Throughput: one byte per cycle, sustained while rsp is not stalled. The decode step for a byte is a
// small counter update between the input register and the rsp register.
// A stalled rsp holds its beat; the input register holds one byte and takes one only if
// empty, then req_tready drops until rsp_tready frees the rsp register.
// Headers and no-op bytes give no rsp beat; bytes after the last row are
// swallowed without result.
// Reset (synchronous, active high) clears the decode state, plane offsets and the
// valid flags of both registers, and loads the reset values of the configuration.
module packbits_planar_decoder_unit
   import pbpd_pkg::*;
#(
   parameter int MAX_PLANES  = MAX_PLANES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // coded_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // plane_index, plane_offset, run_value, run_length, zero fill
   output logic [((OFFSET_BITS+26)/8)*8-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,  // row_overrun
   output logic                                  rsp_tlast,  // image_done
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_ADDR_W-1:0]                 csr_addr,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int RSP_W = ((OFFSET_BITS + 26) / 8) * 8;

   cfg_type cfg;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;

   logic                   emit;
   logic [2:0]             plane_index;
   logic [OFFSET_BITS-1:0] plane_offset;
   logic [7:0]             run_value;
   logic [7:0]             run_length;
   logic                   row_overrun;
   logic                   image_done;
   logic                   finished;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_user_ff;
   logic             rsp_last_ff;

   pbpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbpd_engine #(
      .MAX_PLANES  (MAX_PLANES),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .coded_byte   (in_byte_ff),
      .cfg          (cfg),
      .emit         (emit),
      .plane_index  (plane_index),
      .plane_offset (plane_offset),
      .run_value    (run_value),
      .run_length   (run_length),
      .row_overrun  (row_overrun),
      .image_done   (image_done),
      .finished     (finished)
   );

   // a byte leaves the input register when the rsp slot is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit)  rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && emit) begin
         rsp_data_ff <= RSP_W'({run_length, run_value, plane_offset, plane_index});
         rsp_user_ff <= row_overrun;
         rsp_last_ff <= image_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && image_done) |=> finished)
      else $error("image_done beat did not stop the decoder");

   a_no_run_after_done: assert property (@(posedge clock) disable iff (reset)
      finished |-> !emit)
      else $error("run produced after the last row");

   a_run_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[OFFSET_BITS+18:OFFSET_BITS+11] != 8'd0))
      else $error("run with zero length");

   a_plane_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff[2:0]} < 4'(MAX_PLANES)))
      else $error("plane index beyond plane table");
`endif

endmodule
